[rtl/core/gap_pkg.sv]
// Package for the grid path search: grid size defaults, step costs,
// result status codes and the neighbor direction tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gap_pkg;

  localparam int GRID_W_DEF = 8;
  localparam int GRID_H_DEF = 8;

  localparam int CRD_W  = 3;   // coordinate field width
  localparam int COST_W = 10;  // stored path cost width
  localparam int H_W    = 7;   // heuristic width (largest is 98)
  localparam int F_W    = 11;  // cost plus heuristic
  localparam int DIR_W  = 3;

  localparam logic [COST_W-1:0] COST_STRAIGHT = 10'd10;
  localparam logic [COST_W-1:0] COST_DIAG     = 10'd14;

  typedef logic [1:0] status_t;
  localparam status_t ST_PATH    = 2'd0;
  localparam status_t ST_EMPTY   = 2'd1;
  localparam status_t ST_UNREACH = 2'd2;

  // Column offset of each of the eight neighbors.
  function automatic logic signed [1:0] dir_dx(input logic [DIR_W-1:0] d);
    logic signed [1:0] r;
    unique case (d)
      3'd0, 3'd3, 3'd5: r = -2'sd1;
      3'd1, 3'd6:       r = 2'sd0;
      default:          r = 2'sd1;
    endcase
    return r;
  endfunction

  // Row offset of each of the eight neighbors.
  function automatic logic signed [1:0] dir_dy(input logic [DIR_W-1:0] d);
    logic signed [1:0] r;
    unique case (d)
      3'd0, 3'd1, 3'd2: r = -2'sd1;
      3'd3, 3'd4:       r = 2'sd0;
      default:          r = 2'sd1;
    endcase
    return r;
  endfunction

  function automatic logic dir_diag(input logic [DIR_W-1:0] d);
    return (d != 3'd1) && (d != 3'd3) && (d != 3'd4) && (d != 3'd6);
  endfunction

endpackage
`default_nettype wire

[rtl/core/gap_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/gap_octile.sv]
// Octile distance between two grid cells (straight step 10, diagonal 14).
// Depends on gap_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gap_octile (
  input  wire logic [gap_pkg::CRD_W-1:0] ax,
  input  wire logic [gap_pkg::CRD_W-1:0] ay,
  input  wire logic [gap_pkg::CRD_W-1:0] bx,
  input  wire logic [gap_pkg::CRD_W-1:0] by,
  output logic      [gap_pkg::H_W-1:0]   h_dist
);

  logic [gap_pkg::CRD_W-1:0] adx, ady, mn, mx;

  always_comb begin
    adx  = (ax > bx) ? ax - bx : bx - ax;
    ady  = (ay > by) ? ay - by : by - ay;
    mn   = (adx < ady) ? adx : ady;
    mx   = (adx < ady) ? ady : adx;
    // 14*mn + 10*(mx - mn) = 4*mn + 10*mx
    h_dist = gap_pkg::H_W'({4'd0, mn} << 2) + gap_pkg::H_W'({4'd0, mx} * 7'd10);
  end

endmodule
`default_nettype wire

[rtl/core/grid_astar_path_search.sv]
// Grid path search, A* over eight neighbors with octile costs.
// A query scans all W*H cells of the cost memory once per expanded cell and then makes
// the decision and visits its neighbors; the path is then sent cell by cell, from the goal.
// One item is worked on at a time. Reset (synchronous, rst_n low) clears the blocked
// map through per-cell written flags; the cost memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module grid_astar_path_search #(
  parameter int GRID_WIDTH  = gap_pkg::GRID_W_DEF,
  parameter int GRID_HEIGHT = gap_pkg::GRID_H_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_mode,
  input  wire logic [gap_pkg::CRD_W-1:0]   in_cell_x,
  input  wire logic [gap_pkg::CRD_W-1:0]   in_cell_y,
  input  wire logic                        in_blocked,
  input  wire logic [gap_pkg::CRD_W-1:0]   in_goal_x,
  input  wire logic [gap_pkg::CRD_W-1:0]   in_goal_y,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [gap_pkg::CRD_W-1:0]   out_step_x,
  output logic      [gap_pkg::CRD_W-1:0]   out_step_y,
  output logic      [1:0]                  out_status,
  output logic                             out_last
);

  localparam int NC = GRID_WIDTH * GRID_HEIGHT;
  localparam int CW = $clog2(NC);
  localparam int MW = gap_pkg::DIR_W + gap_pkg::COST_W;
  localparam logic [3:0] WL = 4'(GRID_WIDTH);
  localparam logic [3:0] HL = 4'(GRID_HEIGHT);
  localparam logic [gap_pkg::CRD_W-1:0] XMAX = gap_pkg::CRD_W'(GRID_WIDTH - 1);
  localparam logic [gap_pkg::CRD_W-1:0] YMAX = gap_pkg::CRD_W'(GRID_HEIGHT - 1);
  localparam logic [CW-1:0] NLAST = CW'(NC - 2);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_SCAN      = 7'b0000010,
    S_DECIDE    = 7'b0000100,
    S_EXPAND    = 7'b0001000,
    S_TRACE_RD  = 7'b0010000,
    S_TRACE_OUT = 7'b0100000,
    S_RESULT    = 7'b1000000
  } state_t;

  function automatic logic [CW-1:0] cell_idx(input logic [gap_pkg::CRD_W-1:0] x,
                                             input logic [gap_pkg::CRD_W-1:0] y);
    return CW'(({3'd0, y} * 6'(GRID_WIDTH)) + {3'd0, x});
  endfunction

  function automatic logic in_grid(input logic signed [3:0] x, input logic signed [3:0] y);
    return !x[3] && !y[3] && (x < WL) && (y < HL);
  endfunction

  state_t state_r, state_nxt;

  logic [gap_pkg::CRD_W-1:0] sx_r, sy_r, gx_r, gy_r;
  gap_pkg::status_t          res_st_r, res_st_nxt;
  logic [NC-1:0]             open_r, open_nxt, closed_r, closed_nxt, blk_wr_r, blk_wr_nxt;

  // Scan of the open set.
  logic [gap_pkg::CRD_W-1:0] scx_r, scx_nxt, scy_r, scy_nxt;
  logic                      sc_iss_r, sc_iss_nxt, p_val_r, p_val_nxt;
  logic [gap_pkg::CRD_W-1:0] px_r, py_r;
  logic [CW-1:0]             p_idx_r;
  logic                      found_r, found_nxt;
  logic [gap_pkg::CRD_W-1:0] bx_r, bx_nxt, by_r, by_nxt;
  logic [gap_pkg::F_W-1:0]   bf_r, bf_nxt, p_f;
  logic [gap_pkg::H_W-1:0]   bh_r, bh_nxt, p_h;
  logic [gap_pkg::COST_W-1:0] bg_r, bg_nxt;

  // Neighbor expansion.
  logic [gap_pkg::DIR_W-1:0] d_r, d_nxt;
  logic                      ex_iss_r, ex_iss_nxt, e_val_r, e_val_nxt;
  logic [CW-1:0]             e_idx_r, e_idx_nxt;
  logic [gap_pkg::DIR_W-1:0] e_dir_r;
  logic signed [1:0]         ex_dx, ex_dy;
  logic signed [3:0]         nx4, ny4;
  logic [gap_pkg::COST_W-1:0] ng;

  // Path trace.
  logic [gap_pkg::CRD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [CW-1:0]             n_r, n_nxt;
  logic signed [1:0]         tr_dx, tr_dy;
  logic signed [3:0]         tx4, ty4;
  logic                      t_last;

  // Output register.
  logic                      ov_r, ov_nxt, ol_r, ol_nxt, out_free;
  logic [gap_pkg::CRD_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  gap_pkg::status_t          os_r, os_nxt;

  // Memories.
  logic          cm_we, cm_re, bm_we, bm_re, bm_q;
  logic [CW-1:0] cm_waddr, cm_raddr, bm_raddr;
  logic [MW-1:0] cm_wdata, cm_q;

  logic accept, q_ok;

  gap_ram #(.WIDTH(MW), .DEPTH(NC)) u_cost_ram (
    .clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
    .re(cm_re), .raddr(cm_raddr), .rdata(cm_q)
  );

  gap_ram #(.WIDTH(1), .DEPTH(NC)) u_blk_ram (
    .clk(clk), .we(bm_we), .waddr(cell_idx(in_cell_x, in_cell_y)), .wdata(in_blocked),
    .re(bm_re), .raddr(bm_raddr), .rdata(bm_q)
  );

  gap_octile u_h (.ax(px_r), .ay(py_r), .bx(gx_r), .by(gy_r), .h_dist(p_h));

  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !ov_r || !out_stall;
  assign out_valid  = ov_r;
  assign out_step_x = ox_r;
  assign out_step_y = oy_r;
  assign out_status = os_r;
  assign out_last   = ol_r;

  always_comb begin
    q_ok  = in_grid({1'b0, in_cell_x}, {1'b0, in_cell_y}) &&
            in_grid({1'b0, in_goal_x}, {1'b0, in_goal_y});
    p_f   = gap_pkg::F_W'(cm_q[gap_pkg::COST_W-1:0]) + gap_pkg::F_W'(p_h);
    ex_dx = gap_pkg::dir_dx(d_r);
    ex_dy = gap_pkg::dir_dy(d_r);
    tr_dx = gap_pkg::dir_dx(cm_q[MW-1 -: 3]);
    tr_dy = gap_pkg::dir_dy(cm_q[MW-1 -: 3]);
    nx4   = $signed({1'b0, bx_r}) + {{2{ex_dx[1]}}, ex_dx};
    ny4   = $signed({1'b0, by_r}) + {{2{ex_dy[1]}}, ex_dy};
    ng    = bg_r + (gap_pkg::dir_diag(e_dir_r) ? gap_pkg::COST_DIAG : gap_pkg::COST_STRAIGHT);
    tx4   = $signed({1'b0, cx_r}) - {{2{tr_dx[1]}}, tr_dx};
    ty4   = $signed({1'b0, cy_r}) - {{2{tr_dy[1]}}, tr_dy};
    t_last = !in_grid(tx4, ty4) || ((tx4[2:0] == sx_r) && (ty4[2:0] == sy_r)) ||
             (n_r == NLAST);
  end

  always_comb begin
    state_nxt  = state_r;
    res_st_nxt = res_st_r;
    open_nxt   = open_r;
    closed_nxt = closed_r;
    blk_wr_nxt = blk_wr_r;
    scx_nxt = scx_r; scy_nxt = scy_r; sc_iss_nxt = sc_iss_r; p_val_nxt = 1'b0;
    found_nxt = found_r; bx_nxt = bx_r; by_nxt = by_r;
    bf_nxt = bf_r; bh_nxt = bh_r; bg_nxt = bg_r;
    d_nxt = d_r; ex_iss_nxt = ex_iss_r; e_val_nxt = 1'b0;
    e_idx_nxt = cell_idx(nx4[2:0], ny4[2:0]);
    cx_nxt = cx_r; cy_nxt = cy_r; n_nxt = n_r;
    ov_nxt = out_free ? 1'b0 : ov_r;
    ox_nxt = ox_r; oy_nxt = oy_r; os_nxt = os_r; ol_nxt = ol_r;
    cm_we = 1'b0; cm_waddr = cell_idx(in_cell_x, in_cell_y); cm_wdata = '0;
    cm_re = 1'b0; cm_raddr = cell_idx(scx_r, scy_r);
    bm_we = 1'b0; bm_re = 1'b0; bm_raddr = e_idx_nxt;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_mode) begin
            if (in_grid({1'b0, in_cell_x}, {1'b0, in_cell_y})) begin
              bm_we = 1'b1;
              blk_wr_nxt[cell_idx(in_cell_x, in_cell_y)] = 1'b1;
            end
          end else if (!q_ok) begin
            res_st_nxt = gap_pkg::ST_UNREACH;
            state_nxt  = S_RESULT;
          end else if ((in_cell_x == in_goal_x) && (in_cell_y == in_goal_y)) begin
            res_st_nxt = gap_pkg::ST_EMPTY;
            state_nxt  = S_RESULT;
          end else begin
            // The start cell gets cost zero and is the only open cell.
            cm_we      = 1'b1;
            open_nxt   = '0;
            closed_nxt = '0;
            open_nxt[cell_idx(in_cell_x, in_cell_y)] = 1'b1;
            scx_nxt = '0; scy_nxt = '0; sc_iss_nxt = 1'b1; found_nxt = 1'b0;
            state_nxt  = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (sc_iss_r) begin
          cm_re     = 1'b1;
          p_val_nxt = 1'b1;
          if (scx_r == XMAX) begin
            scx_nxt = '0;
            if (scy_r == YMAX) sc_iss_nxt = 1'b0;
            else scy_nxt = scy_r + 1'b1;
          end else begin
            scx_nxt = scx_r + 1'b1;
          end
        end
        // Cells come in ascending index order, so a strict compare keeps the lowest index.
        if (p_val_r && open_r[p_idx_r] &&
            (!found_r || (p_f < bf_r) || ((p_f == bf_r) && (p_h < bh_r)))) begin
          found_nxt = 1'b1;
          bx_nxt = px_r; by_nxt = py_r;
          bf_nxt = p_f;  bh_nxt = p_h;
          bg_nxt = cm_q[gap_pkg::COST_W-1:0];
        end
        if (!sc_iss_r && !p_val_r) state_nxt = S_DECIDE;
      end

      S_DECIDE: begin
        if (!found_r) begin
          res_st_nxt = gap_pkg::ST_UNREACH;
          state_nxt  = S_RESULT;
        end else if ((bx_r == gx_r) && (by_r == gy_r)) begin
          cx_nxt = gx_r; cy_nxt = gy_r; n_nxt = '0;
          state_nxt = S_TRACE_RD;
        end else begin
          open_nxt[cell_idx(bx_r, by_r)]   = 1'b0;
          closed_nxt[cell_idx(bx_r, by_r)] = 1'b1;
          d_nxt = '0; ex_iss_nxt = 1'b1;
          state_nxt = S_EXPAND;
        end
      end

      S_EXPAND: begin
        if (ex_iss_r) begin
          cm_raddr = e_idx_nxt;
          if (in_grid(nx4, ny4)) begin
            cm_re = 1'b1; bm_re = 1'b1; e_val_nxt = 1'b1;
          end
          d_nxt = d_r + 1'b1;
          if (d_r == 3'd7) ex_iss_nxt = 1'b0;
        end
        // Neighbors of one cell are distinct, so this write never meets the read above.
        if (e_val_r && !(bm_q && blk_wr_r[e_idx_r]) && !closed_r[e_idx_r] &&
            (!open_r[e_idx_r] || (ng < cm_q[gap_pkg::COST_W-1:0]))) begin
          cm_we    = 1'b1;
          cm_waddr = e_idx_r;
          cm_wdata = {e_dir_r, ng};
          open_nxt[e_idx_r] = 1'b1;
        end
        if (!ex_iss_r && !e_val_r) begin
          scx_nxt = '0; scy_nxt = '0; sc_iss_nxt = 1'b1; found_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end

      S_TRACE_RD: begin
        cm_re     = 1'b1;
        cm_raddr  = cell_idx(cx_r, cy_r);
        state_nxt = S_TRACE_OUT;
      end

      S_TRACE_OUT: begin
        if (out_free) begin
          ov_nxt = 1'b1; ox_nxt = cx_r; oy_nxt = cy_r;
          os_nxt = gap_pkg::ST_PATH; ol_nxt = t_last;
          if (t_last) begin
            state_nxt = S_IDLE;
          end else begin
            cx_nxt = tx4[2:0]; cy_nxt = ty4[2:0]; n_nxt = n_r + 1'b1;
            state_nxt = S_TRACE_RD;
          end
        end
      end

      S_RESULT: begin
        if (out_free) begin
          ov_nxt = 1'b1; ox_nxt = '0; oy_nxt = '0;
          os_nxt = res_st_r; ol_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      blk_wr_r <= '0;
      open_r   <= '0;
      closed_r <= '0;
      sc_iss_r <= 1'b0;
      p_val_r  <= 1'b0;
      ex_iss_r <= 1'b0;
      e_val_r  <= 1'b0;
      found_r  <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      blk_wr_r <= blk_wr_nxt;
      open_r   <= open_nxt;
      closed_r <= closed_nxt;
      sc_iss_r <= sc_iss_nxt;
      p_val_r  <= p_val_nxt;
      ex_iss_r <= ex_iss_nxt;
      e_val_r  <= e_val_nxt;
      found_r  <= found_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_mode) begin
      sx_r <= in_cell_x; sy_r <= in_cell_y;
      gx_r <= in_goal_x; gy_r <= in_goal_y;
    end
    res_st_r <= res_st_nxt;
    scx_r <= scx_nxt; scy_r <= scy_nxt;
    px_r <= scx_r; py_r <= scy_r; p_idx_r <= cell_idx(scx_r, scy_r);
    bx_r <= bx_nxt; by_r <= by_nxt;
    bf_r <= bf_nxt; bh_r <= bh_nxt; bg_r <= bg_nxt;
    d_r <= d_nxt; e_idx_r <= e_idx_nxt; e_dir_r <= d_r;
    cx_r <= cx_nxt; cy_r <= cy_nxt; n_r <= n_nxt;
    ox_r <= ox_nxt; oy_r <= oy_nxt; os_r <= os_nxt; ol_r <= ol_nxt;
  end

endmodule
`default_nettype wire

[verif/grid_astar_path_search_tb.sv]
// Testbench for grid_astar_path_search: map writes and path queries, checked
// against an in-bench A* path predictor held in a small scoreboard class.
// Depends on gap_pkg and the grid_astar_path_search RTL.
`timescale 1ns / 1ps
module grid_astar_path_search_tb;

  localparam int GW = 8;
  localparam int GH = 8;
  localparam int NCELL = GW * GH;
  localparam int IDLE_LIMIT = 200000;

  typedef struct packed {
    logic [2:0]       x;
    logic [2:0]       y;
    gap_pkg::status_t status;
    logic             last;
  } path_step_t;

  class path_scoreboard;
    bit         wall[NCELL];
    int         g_cost[NCELL];
    int         parent_dir[NCELL];
    path_step_t pending[$];
    int         errors;

    function new();
      foreach (wall[i]) wall[i] = 0;
      errors = 0;
    endfunction

    function int octile_dist(int x1, int y1, int x2, int y2);
      int ax, ay, mn, mx;
      ax = x1 > x2 ? x1 - x2 : x2 - x1;
      ay = y1 > y2 ? y1 - y2 : y2 - y1;
      mn = ax < ay ? ax : ay;
      mx = ax < ay ? ay : ax;
      return 14 * mn + 10 * (mx - mn);
    endfunction

    function void push_step(int x, int y, gap_pkg::status_t st, bit lst);
      path_step_t s;
      s.x = 3'(x); s.y = 3'(y); s.status = st; s.last = lst;
      pending = {pending, s};
    endfunction

    // Notes one accepted transfer on the input side.
    function void note_item(bit mode, int sx, int sy, bit blk, int gx, int gy);
      bit open_c[NCELL];
      bit closed_c[NCELL];
      int start, goal, best, bf, bh, h, f, cx, cy, nx, ny, ni, ng, cur, n, dd, first;
      bit found;
      if (!mode) begin
        wall[sy * GW + sx] = blk;
        return;
      end
      if (sx == gx && sy == gy) begin
        push_step(0, 0, gap_pkg::ST_EMPTY, 1);
        return;
      end
      start = sy * GW + sx;
      goal = gy * GW + gx;
      foreach (open_c[i]) begin
        open_c[i] = 0;
        closed_c[i] = 0;
      end
      g_cost[start] = 0;
      open_c[start] = 1;
      found = 0;
      forever begin
        best = -1; bf = 0; bh = 0;
        for (int i = 0; i < NCELL; i++) begin
          if (open_c[i]) begin
            h = octile_dist(i % GW, i / GW, gx, gy);
            f = g_cost[i] + h;
            if (best < 0 || f < bf || (f == bf && h < bh)) begin
              best = i; bf = f; bh = h;
            end
          end
        end
        if (best < 0) break;
        if (best == goal) begin
          found = 1;
          break;
        end
        open_c[best] = 0;
        closed_c[best] = 1;
        cx = best % GW;
        cy = best / GW;
        for (int d = 0; d < 8; d++) begin
          nx = cx + gap_pkg::dir_dx(3'(d));
          ny = cy + gap_pkg::dir_dy(3'(d));
          if (nx >= 0 && nx < GW && ny >= 0 && ny < GH) begin
            ni = ny * GW + nx;
            if (!wall[ni] && !closed_c[ni]) begin
              ng = g_cost[best] + (gap_pkg::dir_diag(3'(d)) ? 14 : 10);
              if (!open_c[ni] || ng < g_cost[ni]) begin
                g_cost[ni] = ng & 10'h3FF;
                parent_dir[ni] = d;
                open_c[ni] = 1;
              end
            end
          end
        end
      end
      if (!found) begin
        push_step(0, 0, gap_pkg::ST_UNREACH, 1);
        return;
      end
      // Walk the parent links from the goal; the start cell is not sent.
      cur = goal;
      n = 0;
      first = pending.size();
      while (cur != start && n < NCELL - 1) begin
        cx = cur % GW;
        cy = cur / GW;
        dd = parent_dir[cur];
        push_step(cx, cy, gap_pkg::ST_PATH, 0);
        n++;
        cx -= gap_pkg::dir_dx(3'(dd));
        cy -= gap_pkg::dir_dy(3'(dd));
        if (cx < 0 || cx >= GW || cy < 0 || cy >= GH) break;
        cur = cy * GW + cx;
      end
      pending[first + n - 1].last = 1;
    endfunction

    // Compares one accepted transfer on the result side with the oldest expectation.
    function void check_step(path_step_t got);
      path_step_t exp_s;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d status=%0d last=%0d", $time,
                 got.x, got.y, got.status, got.last);
        errors++;
        return;
      end
      exp_s = pending.pop_front();
      if (got.x !== exp_s.x) begin
        $display("%0t: step_x expected %0d actual %0d", $time, exp_s.x, got.x);
        errors++;
      end
      if (got.y !== exp_s.y) begin
        $display("%0t: step_y expected %0d actual %0d", $time, exp_s.y, got.y);
        errors++;
      end
      if (got.status !== exp_s.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_s.status, got.status);
        errors++;
      end
      if (got.last !== exp_s.last) begin
        $display("%0t: last expected %0d actual %0d", $time, exp_s.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_mode;
  logic [2:0] in_cell_x;
  logic [2:0] in_cell_y;
  logic       in_blocked;
  logic [2:0] in_goal_x;
  logic [2:0] in_goal_y;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_step_x;
  logic [2:0] out_step_y;
  logic [1:0] out_status;
  logic       out_last;

  path_scoreboard sb;
  bit   sink_busy_idle;
  int   idle_cycles;

  grid_astar_path_search dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_cell_x(in_cell_x), .in_cell_y(in_cell_y), .in_blocked(in_blocked),
    .in_goal_x(in_goal_x), .in_goal_y(in_goal_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_step_x(out_step_x),
    .out_step_y(out_step_y), .out_status(out_status), .out_last(out_last)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Result side: random stalls except during the quiet stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_step('{out_step_x, out_step_y, out_status, out_last});
      out_stall <= sink_busy_idle ? 1'b0 : ($urandom_range(99) < 37);
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sends one item, with a random gap before it unless gaps are off.
  task automatic send_item(bit mode, int cx, int cy, bit blk, int gx, int gy, bit gaps);
    while (gaps && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_cell_x  <= 3'(cx);
    in_cell_y  <= 3'(cy);
    in_blocked <= blk;
    in_goal_x  <= 3'(gx);
    in_goal_y  <= 3'(gy);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(mode, cx, cy, blk, gx, gy);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic clear_map(bit gaps);
    for (int i = 0; i < NCELL; i++)
      send_item(0, i % GW, i / GW, 0, $urandom_range(7), $urandom_range(7), gaps);
  endtask

  initial begin
    int wall_pct;
    sb = new();
    sink_busy_idle = 0;
    rst_n = 0;
    in_valid = 0; in_mode = 0; in_cell_x = 0; in_cell_y = 0;
    in_blocked = 0; in_goal_x = 0; in_goal_y = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: open grid corner to corner, start equals goal, a wall with a gap,
    // a blocked goal, a fully enclosed goal and a blocked start.
    send_item(1, 0, 0, 1, 7, 7, 1);
    send_item(1, 7, 7, 0, 0, 0, 1);
    send_item(1, 7, 0, 1, 0, 7, 1);
    send_item(1, 3, 3, 0, 3, 3, 1);
    for (int y = 0; y < 7; y++) send_item(0, 4, y, 1, 0, 0, 1);
    send_item(1, 0, 0, 0, 7, 0, 1);
    send_item(0, 7, 7, 1, 0, 0, 1);
    send_item(1, 0, 0, 0, 7, 7, 1);
    send_item(0, 7, 7, 0, 7, 7, 1);
    send_item(0, 6, 6, 1, 0, 0, 1);
    send_item(0, 6, 7, 1, 0, 0, 1);
    send_item(0, 7, 6, 1, 0, 0, 1);
    send_item(1, 0, 0, 0, 7, 7, 1);
    send_item(0, 0, 0, 1, 0, 0, 1);
    send_item(1, 0, 0, 0, 2, 2, 1);
    send_item(1, 0, 0, 0, 0, 0, 1);
    drain_results();
    clear_map(1);

    // Random phases: varying wall density, with map writes and queries mixed at random.
    for (int ph = 0; ph < 8; ph++) begin
      wall_pct = ph * 10;
      sink_busy_idle = (ph == 3);
      for (int k = 0; k < 30; k++) begin
        if ($urandom_range(99) < 45)
          send_item(0, $urandom_range(7), $urandom_range(7),
                    $urandom_range(99) < wall_pct, $urandom, $urandom, ph != 3);
        else
          send_item(1, $urandom_range(7), $urandom_range(7), 1'($urandom),
                    $urandom_range(7), $urandom_range(7), ph != 3);
      end
      // After every third phase, hold off until every pending path has come out.
      if (ph % 3 == 2) drain_results();
    end
    sink_busy_idle = 0;
    drain_results();
    repeat (200) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/gap_pkg.sv
rtl/core/gap_ram.sv
rtl/core/gap_octile.sv
rtl/core/grid_astar_path_search.sv
verif/grid_astar_path_search_tb.sv
